### rtl/lft_pkg.sv
// Package: payload types, register codes and the exponential factor table for the friction block.
`timescale 1ns / 1ps
package lft_pkg;

   typedef struct packed {
      logic [2:0]         joint;
      logic signed [31:0] velocity;
   } req_type;

   typedef struct packed {
      logic [2:0]         joint_out;
      logic signed [31:0] friction_torque;
   } rsp_type;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_STIFFNESS = 3'd0,
      REG_DAMPING   = 3'd1,
      REG_VISCOUS   = 3'd2,
      REG_COULOMB   = 3'd3,
      REG_STATIC    = 3'd4,
      REG_STRIBECK  = 3'd5,
      REG_TIME_STEP = 3'd6
   } reg_index_type;

   localparam logic [31:0] RST_STIFFNESS = 32'd180224000;
   localparam logic [31:0] RST_DAMPING   = 32'd2962227;
   localparam logic [31:0] RST_VISCOUS   = 32'd119211;
   localparam logic [31:0] RST_COULOMB   = 32'd457114;
   localparam logic [31:0] RST_STATIC    = 32'd581632;
   localparam logic [31:0] RST_STRIBECK  = 32'd4004;
   localparam logic [31:0] RST_TIME_STEP = 32'd4294967;

   localparam logic [4:0]  EXP_TERMS = 5'd20;
   localparam logic [6:0]  MUL_STEPS = 7'd48;
   localparam logic [6:0]  DIV_STEPS = 7'd80;
   localparam logic [16:0] E_ONE     = 17'd65536;

   // exp(-2^(k-16)) in Q0.16
   function automatic logic [15:0] exp_factor(input logic [4:0] k);
      logic [15:0] f;
      case (k)
         5'd0:    f = 16'd65535;
         5'd1:    f = 16'd65534;
         5'd2:    f = 16'd65532;
         5'd3:    f = 16'd65528;
         5'd4:    f = 16'd65520;
         5'd5:    f = 16'd65504;
         5'd6:    f = 16'd65472;
         5'd7:    f = 16'd65408;
         5'd8:    f = 16'd65280;
         5'd9:    f = 16'd65026;
         5'd10:   f = 16'd64520;
         5'd11:   f = 16'd63520;
         5'd12:   f = 16'd61565;
         5'd13:   f = 16'd57835;
         5'd14:   f = 16'd51039;
         5'd15:   f = 16'd39750;
         5'd16:   f = 16'd24109;
         5'd17:   f = 16'd8869;
         5'd18:   f = 16'd1200;
         5'd19:   f = 16'd22;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

endpackage

### rtl/lugre_friction_torque.sv
// LuGre friction torque per joint, built on a shared bit-serial multiplier and divider.
//
// Usage: req channel (valid/ready) carries a joint index and a signed Q16.16
// velocity; rsp channel (valid/ready) returns the joint index and the saturated
// Q16.16 friction torque. One item is in work at a time; req_ready is high only
// while the sequencer is idle. Seven gains and levels sit behind the APB port.
// Arithmetic: a shift-add multiplier and a restoring divider work one bit per
// cycle. Zero velocity skips the divider and the bristle update; nonzero velocity
// skips the exponential when the Stribeck ratio reaches 4, else it adds one
// product for each set bit of the squared ratio (up to 20). The next item is
// taken in the cycle after its predecessor's result is loaded.
// A joint at or beyond JOINTS returns torque 0 without any computation.
// Reset loads the register defaults and marks every bristle deflection as zero.
// A stalled receiver holds the result in the output register; the next item
// is taken meanwhile and its result waits until the register is free.
`timescale 1ns / 1ps
module lugre_friction_torque
   import lft_pkg::*;
#(
   parameter int JOINTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_LOAD, S_XDIV, S_XSQ, S_EXPCHK, S_EXPMUL, S_GSTART,
      S_G1, S_G2, S_TMUL, S_TDIV, S_DTMUL, S_T0, S_T1, S_T2, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] sigma0_ff, sigma0_in, sigma1_ff, sigma1_in, sigma2_ff, sigma2_in;
   logic [31:0] fc_ff, fc_in, fs_ff, fs_in, vs_ff, vs_in, dt_ff, dt_in;

   logic [2:0]         joint_ff, joint_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [31:0] v_ff, v_in;
   logic [31:0]        av_ff, av_in;
   logic signed [47:0] z_ff, z_in, dz_ff, dz_in;
   logic signed [49:0] tq_ff, tq_in;
   logic signed [31:0] tq32_ff, tq32_in;
   logic [19:0]        u_ff, u_in;
   logic [4:0]         k_ff, k_in;
   logic [16:0]        e_ff, e_in;
   logic [47:0]        gp_ff, gp_in;
   logic [31:0]        g_ff, g_in;
   logic [JOINTS-1:0]  valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [31:0] ma_ff, ma_in;
   logic [79:0] mp_ff, mp_in;
   logic [31:0] dd_ff, dd_in, dr_ff, dr_in;
   logic [79:0] dq_ff, dq_in;
   logic [6:0]  cnt_ff, cnt_in;

   logic signed [47:0] z_mem [JOINTS];
   logic signed [47:0] z_rd_ff;
   logic               mem_we;

   logic        mul_go, div_go, step_mul, step_div;
   logic [31:0] mul_a, div_d;
   logic [47:0] mul_b;
   logic [79:0] div_n;

   logic [32:0] msum, dtw, dsub;
   logic        dge;

   logic signed [47:0] zload, dz_sat, z_new;
   logic signed [49:0] vext, tval, dzw, zw, inc50, tsum;
   logic [48:0]        tcap;
   logic [47:0]        gsum;
   logic [31:0]        gval;

   function automatic logic [47:0] abs48(input logic signed [47:0] x);
      return x[47] ? (~x + 48'd1) : x;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] w);
      logic signed [47:0] r;
      if (w[49:47] == 3'b000 || w[49:47] == 3'b111) begin
         r = w[47:0];
      end else if (w[49]) begin
         r = {1'b1, 47'd0};
      end else begin
         r = {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] w);
      logic signed [31:0] r;
      if (w[49:31] == '0 || w[49:31] == '1) begin
         r = w[31:0];
      end else if (w[49]) begin
         r = {1'b1, 31'd0};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [49:0] signed_term(input logic neg, input logic [47:0] t);
      logic signed [49:0] s;
      s = {2'b00, t};
      return neg ? -s : s;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (paddr[4:2])
         REG_STIFFNESS: prdata = sigma0_ff;
         REG_DAMPING:   prdata = sigma1_ff;
         REG_VISCOUS:   prdata = sigma2_ff;
         REG_COULOMB:   prdata = fc_ff;
         REG_STATIC:    prdata = fs_ff;
         REG_STRIBECK:  prdata = vs_ff;
         REG_TIME_STEP: prdata = dt_ff;
         default:       prdata = '0;
      endcase
   end

   assign msum = {1'b0, mp_ff[79:48]} + (mp_ff[0] ? {1'b0, ma_ff} : 33'd0);
   assign dtw  = {dr_ff, dq_ff[79]};
   assign dge  = (dtw >= {1'b0, dd_ff});
   assign dsub = dtw - {1'b0, dd_ff};

   assign zload = valid_ff[idx_ff] ? z_rd_ff : '0;
   assign vext  = {{2{v_ff[31]}}, v_ff, 16'd0};
   assign tcap  = (dq_ff[79:49] != '0 || (dq_ff[48] && dq_ff[47:0] != '0)) ?
                  {1'b1, 48'd0} : dq_ff[48:0];
   assign tval  = {1'b0, tcap};
   assign dzw   = z_ff[47] ? vext + tval : vext - tval;
   assign dz_sat = sat48(dzw);
   assign zw    = {{2{z_ff[47]}}, z_ff};
   assign inc50 = {2'b00, mp_ff[79:32]};
   assign z_new = sat48(dz_ff[47] ? zw - inc50 : zw + inc50);
   assign gsum  = gp_ff + mp_ff[47:0];
   assign gval  = (gsum[47:16] == '0) ? 32'd1 : gsum[47:16];
   assign tsum  = tq_ff + signed_term(v_ff[31], mp_ff[63:16]);

   always_comb begin
      state_in     = state_ff;
      sigma0_in    = sigma0_ff;
      sigma1_in    = sigma1_ff;
      sigma2_in    = sigma2_ff;
      fc_in        = fc_ff;
      fs_in        = fs_ff;
      vs_in        = vs_ff;
      dt_in        = dt_ff;
      joint_in     = joint_ff;
      idx_in       = idx_ff;
      v_in         = v_ff;
      av_in        = av_ff;
      z_in         = z_ff;
      dz_in        = dz_ff;
      tq_in        = tq_ff;
      tq32_in      = tq32_ff;
      u_in         = u_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      gp_in        = gp_ff;
      g_in         = g_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ma_in        = ma_ff;
      mp_in        = mp_ff;
      dd_in        = dd_ff;
      dr_in        = dr_ff;
      dq_in        = dq_ff;
      cnt_in       = cnt_ff;
      mem_we       = 1'b0;
      mul_go       = 1'b0;
      div_go       = 1'b0;
      step_mul     = 1'b0;
      step_div     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_d        = '0;
      div_n        = '0;

      if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            REG_STIFFNESS: sigma0_in = pwdata;
            REG_DAMPING:   sigma1_in = pwdata;
            REG_VISCOUS:   sigma2_in = pwdata;
            REG_COULOMB:   fc_in = pwdata;
            REG_STATIC:    fs_in = pwdata;
            REG_STRIBECK:  vs_in = pwdata;
            REG_TIME_STEP: dt_in = pwdata;
            default:       ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               joint_in = req_data.joint;
               idx_in   = IDX_W'(req_data.joint);
               v_in     = req_data.velocity;
               av_in    = req_data.velocity[31] ? (~req_data.velocity + 32'd1)
                                                : req_data.velocity;
               if (32'(req_data.joint) >= JOINTS) begin
                  tq32_in  = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: begin
            z_in  = zload;
            dz_in = '0;
            if (v_ff == '0) begin
               mul_go   = 1'b1;
               mul_a    = sigma0_ff;
               mul_b    = abs48(zload);
               state_in = S_T0;
            end else begin
               div_go   = 1'b1;
               div_n    = {32'd0, av_ff, 16'd0};
               div_d    = vs_ff;
               state_in = S_XDIV;
            end
         end
         S_XDIV: begin
            if (cnt_ff != '0) begin
               step_div = 1'b1;
            end else if (dq_ff[79:18] != '0) begin
               e_in     = '0;
               state_in = S_GSTART;
            end else begin
               mul_go   = 1'b1;
               mul_a    = {14'd0, dq_ff[17:0]};
               mul_b    = {30'd0, dq_ff[17:0]};
               state_in = S_XSQ;
            end
         end
         S_XSQ: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               u_in     = mp_ff[35:16];
               e_in     = E_ONE;
               k_in     = '0;
               state_in = S_EXPCHK;
            end
         end
         S_EXPCHK: begin
            if (k_ff == EXP_TERMS) begin
               state_in = S_GSTART;
            end else if (u_ff[0]) begin
               mul_go   = 1'b1;
               mul_a    = {16'd0, exp_factor(k_ff)};
               mul_b    = {31'd0, e_ff};
               state_in = S_EXPMUL;
            end else begin
               u_in = u_ff >> 1;
               k_in = k_ff + 5'd1;
            end
         end
         S_EXPMUL: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               e_in     = 17'((mp_ff[32:0] + 33'd32768) >> 16);
               u_in     = u_ff >> 1;
               k_in     = k_ff + 5'd1;
               state_in = S_EXPCHK;
            end
         end
         S_GSTART: begin
            mul_go   = 1'b1;
            mul_a    = fc_ff;
            mul_b    = {31'd0, E_ONE - e_ff};
            state_in = S_G1;
         end
         S_G1: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               gp_in    = mp_ff[47:0];
               mul_go   = 1'b1;
               mul_a    = fs_ff;
               mul_b    = {31'd0, e_ff};
               state_in = S_G2;
            end
         end
         S_G2: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               g_in     = gval;
               mul_go   = 1'b1;
               mul_a    = av_ff;
               mul_b    = abs48(z_ff);
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               div_go   = 1'b1;
               div_n    = mp_ff;
               div_d    = g_ff;
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            if (cnt_ff != '0) begin
               step_div = 1'b1;
            end else begin
               dz_in    = dz_sat;
               mul_go   = 1'b1;
               mul_a    = dt_ff;
               mul_b    = abs48(dz_sat);
               state_in = S_DTMUL;
            end
         end
         S_DTMUL: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               z_in             = z_new;
               mem_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               mul_go           = 1'b1;
               mul_a            = sigma0_ff;
               mul_b            = abs48(z_new);
               state_in         = S_T0;
            end
         end
         S_T0: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               tq_in    = signed_term(z_ff[47], mp_ff[79:32]);
               mul_go   = 1'b1;
               mul_a    = sigma1_ff;
               mul_b    = abs48(dz_ff);
               state_in = S_T1;
            end
         end
         S_T1: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               tq_in    = tq_ff + signed_term(dz_ff[47], mp_ff[79:32]);
               mul_go   = 1'b1;
               mul_a    = sigma2_ff;
               mul_b    = {16'd0, av_ff};
               state_in = S_T2;
            end
         end
         S_T2: begin
            if (cnt_ff != '0) begin
               step_mul = 1'b1;
            end else begin
               tq32_in  = sat32(tsum);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{joint_out: joint_ff, friction_torque: tq32_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (mul_go) begin
         ma_in  = mul_a;
         mp_in  = {32'd0, mul_b};
         cnt_in = MUL_STEPS;
      end else if (div_go) begin
         dd_in  = div_d;
         dr_in  = '0;
         dq_in  = div_n;
         cnt_in = DIV_STEPS;
      end else if (step_mul) begin
         mp_in  = {msum, mp_ff[47:1]};
         cnt_in = cnt_ff - 7'd1;
      end else if (step_div) begin
         dr_in  = dge ? dsub[31:0] : dtw[31:0];
         dq_in  = {dq_ff[78:0], dge};
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sigma0_ff    <= RST_STIFFNESS;
         sigma1_ff    <= RST_DAMPING;
         sigma2_ff    <= RST_VISCOUS;
         fc_ff        <= RST_COULOMB;
         fs_ff        <= RST_STATIC;
         vs_ff        <= RST_STRIBECK;
         dt_ff        <= RST_TIME_STEP;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sigma0_ff    <= sigma0_in;
         sigma1_ff    <= sigma1_in;
         sigma2_ff    <= sigma2_in;
         fc_ff        <= fc_in;
         fs_ff        <= fs_in;
         vs_ff        <= vs_in;
         dt_ff        <= dt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      joint_ff    <= joint_in;
      idx_ff      <= idx_in;
      v_ff        <= v_in;
      av_ff       <= av_in;
      z_ff        <= z_in;
      dz_ff       <= dz_in;
      tq_ff       <= tq_in;
      tq32_ff     <= tq32_in;
      u_ff        <= u_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      gp_ff       <= gp_in;
      g_ff        <= g_in;
      rsp_data_ff <= rsp_data_in;
      ma_ff       <= ma_in;
      mp_ff       <= mp_in;
      dd_ff       <= dd_in;
      dr_ff       <= dr_in;
      dq_ff       <= dq_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         z_mem[idx_ff] <= z_new;
      end
      z_rd_ff <= z_mem[idx_ff];
   end

endmodule
